>>> design/dpr_pkg.sv
`default_nettype none

package dpr_pkg;

  localparam int BUF_SIZE_DEFAULT = 2048;
  localparam int MAX_RESULTS      = 4;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] HEX_BAD   = 8'hFF;

  typedef enum logic [1:0] {
    KIND_BODY = 2'd0,
    KIND_TX   = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_MISMATCH  = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_RESTARTED = 2'd3
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    status_t     status;
    logic        has_sequence;
  } result_t;

  typedef struct packed {
    logic [2:0]    count;
    result_t [3:0] res;
  } group_t;

  function automatic logic [7:0] hexval(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    else v = HEX_BAD;
    return v;
  endfunction

endpackage

`default_nettype wire

>>> design/dpr_core.sv
`default_nettype none

module dpr_core import dpr_pkg::*; #(
  parameter int BUF_SIZE = BUF_SIZE_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,
  input  wire logic       grp_free,
  output logic            grp_wr,
  output group_t          grp
);

  localparam int CNT_W = $clog2(BUF_SIZE);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BODY = 2'd1,
    PH_DIG1 = 2'd2,
    PH_DIG2 = 2'd3
  } phase_t;

  phase_t           phase, phase_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [CNT_W-1:0] body_count, body_count_next;
  logic [7:0]       upper_digit, upper_digit_next;
  logic [7:0]       head_bytes [3];
  logic             in_valid;
  logic [7:0]       in_byte;
  logic             consume;
  logic             head_wr;
  logic [7:0]       hv;
  logic [7:0]       xs;
  logic             seq;
  group_t           grp_c;

  always_comb begin
    phase_next       = phase;
    running_sum_next = running_sum;
    body_count_next  = body_count;
    upper_digit_next = upper_digit;
    head_wr          = 1'b0;
    grp_c            = '0;
    hv               = hexval(in_byte);
    xs               = upper_digit + hv;
    seq              = (body_count >= CNT_W'(3)) && (head_bytes[2] == CH_COLON);
    unique case (phase)
      PH_HUNT: begin
        if (in_byte == CH_DOLLAR) begin
          phase_next       = PH_BODY;
          running_sum_next = '0;
          body_count_next  = '0;
        end
      end
      PH_BODY: begin
        priority if (in_byte == CH_DOLLAR) begin
          grp_c.count         = 3'd1;
          grp_c.res[0].kind   = KIND_END;
          grp_c.res[0].status = ST_RESTARTED;
          running_sum_next    = '0;
          body_count_next     = '0;
        end else if (in_byte == CH_HASH) begin
          phase_next = PH_DIG1;
        end else begin
          running_sum_next  = running_sum + in_byte;
          head_wr           = body_count < CNT_W'(3);
          body_count_next   = body_count + CNT_W'(1);
          grp_c.count       = 3'd1;
          grp_c.res[0].kind = KIND_BODY;
          grp_c.res[0].data = in_byte;
          if (body_count_next == CNT_W'(BUF_SIZE - 1)) begin
            grp_c.count         = 3'd2;
            grp_c.res[1].kind   = KIND_END;
            grp_c.res[1].status = ST_TOO_LONG;
            phase_next          = PH_HUNT;
          end
        end
      end
      PH_DIG1: begin
        upper_digit_next = {hv[3:0], 4'h0};
        phase_next       = PH_DIG2;
      end
      PH_DIG2: begin
        phase_next        = PH_HUNT;
        grp_c.res[0].kind = KIND_TX;
        if (xs != running_sum) begin
          grp_c.count         = 3'd2;
          grp_c.res[0].data   = CH_MINUS;
          grp_c.res[1].kind   = KIND_END;
          grp_c.res[1].status = ST_MISMATCH;
        end else if (seq) begin
          grp_c.count               = 3'd4;
          grp_c.res[0].data         = CH_PLUS;
          grp_c.res[1].kind         = KIND_TX;
          grp_c.res[1].data         = head_bytes[0];
          grp_c.res[2].kind         = KIND_TX;
          grp_c.res[2].data         = head_bytes[1];
          grp_c.res[3].kind         = KIND_END;
          grp_c.res[3].status       = ST_GOOD;
          grp_c.res[3].has_sequence = 1'b1;
        end else begin
          grp_c.count         = 3'd2;
          grp_c.res[0].data   = CH_PLUS;
          grp_c.res[1].kind   = KIND_END;
          grp_c.res[1].status = ST_GOOD;
        end
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  assign consume  = in_valid && ((grp_c.count == 3'd0) || grp_free);
  assign s_tready = !in_valid || consume;
  assign grp_wr   = consume && (grp_c.count != 3'd0);
  assign grp      = grp_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      phase       <= PH_HUNT;
      running_sum <= '0;
      body_count  <= '0;
      upper_digit <= '0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (consume) begin
        phase       <= phase_next;
        running_sum <= running_sum_next;
        body_count  <= body_count_next;
        upper_digit <= upper_digit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_byte <= s_tdata;
    if (consume && head_wr) head_bytes[body_count[1:0]] <= in_byte;
  end

  assert property (@(posedge clk) disable iff (rst) grp_wr |-> grp_free)
    else $error("result group written while previous group still draining");

  assert property (@(posedge clk) disable iff (rst)
    grp_wr |-> (grp.count != 3'd0 && grp.count <= 3'(MAX_RESULTS)))
    else $error("result group count out of range");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !consume) |=> (in_valid && $stable(in_byte) && $stable(phase)))
    else $error("held input byte or phase changed while stalled");

endmodule

`default_nettype wire

>>> design/dpr_serializer.sv
`default_nettype none

module dpr_serializer import dpr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        grp_wr,
  input  wire group_t      grp,
  output logic             grp_free,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);

  group_t     held;
  logic [2:0] left;
  logic [1:0] idx;
  result_t    cur;

  assign cur      = held.res[idx];
  assign m_tvalid = left != 3'd0;
  assign m_tlast  = left == 3'd1;
  assign m_tuser  = cur.kind;
  assign m_tdata  = {5'd0, cur.has_sequence, cur.status, cur.data};
  assign grp_free = (left == 3'd0) || (left == 3'd1 && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      idx  <= '0;
    end else if (grp_wr) begin
      left <= grp.count;
      idx  <= '0;
    end else if (m_tvalid && m_tready) begin
      left <= left - 3'd1;
      idx  <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_wr) held <= grp;
  end

endmodule

`default_nettype wire

>>> design/debug_packet_receiver.sv
// A taken byte is registered in the core, and its results in the serializer's group register.
// Throughput: one byte per cycle while each byte yields at most one result and m_tready is high;
// a byte with more results holds the single result port until all are sent, up to 4 per byte.
// Reset: synchronous rst returns to hunting for '$' with sum, count and digit cleared;
// the stored first body bytes are not reset.
`default_nettype none

module debug_packet_receiver import dpr_pkg::*; #(
  parameter int BUF_SIZE = BUF_SIZE_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // rx_byte[7:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // data[7:0], status[9:8], has_sequence[10], zero
  output logic [1:0]       m_tuser,   // kind[1:0]
  output logic             m_tlast
);

  logic   grp_free;
  logic   grp_wr;
  group_t grp;

  dpr_core #(.BUF_SIZE(BUF_SIZE)) u_core (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .grp_free (grp_free),
    .grp_wr   (grp_wr),
    .grp      (grp)
  );

  dpr_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .grp_wr   (grp_wr),
    .grp      (grp),
    .grp_free (grp_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
